### hw/rtl/ahfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_pkg
// Shared types, codes and helpers of the ASCII-hex frame receiver.
// ----------------------------------------------------------------------------
package ahfr_pkg;

  // Byte position counter covers the longest frame: 17 + 4095
  localparam int unsigned POS_W = 13;

  // Frame layout landmarks (byte positions)
  localparam int unsigned HEADER_LAST_POS = 12;  // last LENID digit
  localparam int unsigned MIN_BUFFER_POS  = 17;  // buffers under 18 bytes are short
  localparam int unsigned INFO_FIRST_POS  = 13;  // first info character
  localparam int unsigned CHK_DIGITS      = 4;   // checksum hex digits

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE   = 8'h0D;

  // Reset values of the configuration registers
  localparam logic [7:0] VERSION_RESET = 8'd32;
  localparam logic [7:0] GROUP_RESET   = 8'd70;

  localparam int unsigned CFG_INDEX_W = 1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EXPECTED_VERSION = 1'b0,
    REG_EXPECTED_GROUP   = 1'b1
  } cfg_reg_e;

  // Frame status codes; CHK_HEX_FAULT is held internally only
  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_SHORT_HEADER  = 4'd1,
    ST_BAD_START     = 4'd2,
    ST_BAD_HEX       = 4'd3,
    ST_BAD_VERSION   = 4'd4,
    ST_BAD_GROUP     = 4'd5,
    ST_BAD_CHECKSUM  = 4'd6,
    ST_SHORT_PAYLOAD = 4'd7,
    ST_BAD_END       = 4'd8,
    ST_CHK_HEX_FAULT = 4'd9
  } status_e;

  // Input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } item_t;

  // Result word
  typedef struct packed {
    logic        is_status;
    logic [7:0]  info_char;
    logic [3:0]  status;
    logic [7:0]  address;
    logic [7:0]  return_code;
    logic [11:0] info_length;
  } result_t;

  // Configured match values
  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] expected_group_code;
  } cfg_t;

  // Decode one hex digit, either case: {not_hex, nibble}; nibble is 0 when not hex
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b1, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

### hw/rtl/ahfr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_cfg_regs
// Configuration registers: expected version and expected group code.
// ----------------------------------------------------------------------------
module ahfr_cfg_regs
  import ahfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output cfg_t                   cfg
);

  // Writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version    <= VERSION_RESET;
      cfg.expected_group_code <= GROUP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_EXPECTED_VERSION: cfg.expected_version    <= cfg_data;
        REG_EXPECTED_GROUP:   cfg.expected_group_code <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/ahfr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_in_stage
// Input register: holds one received word until the parser consumes it.
// ----------------------------------------------------------------------------
module ahfr_in_stage
  import ahfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held
);

  // Stall while a word is held and the parser cannot take it
  assign item_stall = held_valid && !advance;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

endmodule

### hw/rtl/ahfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_parser
// Frame state and per-byte checks: header decode, LENID check, info
// pass-through, checksum accumulation and the frame verdict.
// ----------------------------------------------------------------------------
module ahfr_parser
  import ahfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   held,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [3:0]       hi_nibble, hi_nibble_next;
  logic [7:0]       hdr_version, hdr_version_next;
  logic [7:0]       hdr_address, hdr_address_next;
  logic [7:0]       hdr_group, hdr_group_next;
  logic [7:0]       hdr_return, hdr_return_next;
  logic [15:0]      length_word, length_word_next;
  logic [15:0]      rx_checksum, rx_checksum_next;
  status_e          pend_err, pend_err_next;
  logic             verdict_given, verdict_given_next;

  logic [7:0]       b;
  logic             last;
  logic [4:0]       hex;
  logic [7:0]       pair;
  logic [5:0]       nib_sum;
  logic [5:0]       nib_neg;
  logic [POS_W-1:0] info_end;
  logic [POS_W-1:0] frame_end;
  logic [15:0]      sum_neg;
  logic             verdict_hit;
  logic             info_hit;
  logic             clear_hit;
  status_e          verdict_code;

  assign b    = held.rx_byte;
  assign last = held.last_byte;
  assign hex  = hex_value(b);
  assign pair = {hi_nibble, hex[3:0]};

  // LENID check: top nibble is minus the sum of the low three nibbles
  assign nib_sum = {2'b00, length_word[11:8]} + {2'b00, pair[7:4]} + {2'b00, pair[3:0]};
  assign nib_neg = 6'd0 - nib_sum;

  // Frame landmarks from the info length
  assign info_end  = POS_W'(INFO_FIRST_POS) + {1'b0, length_word[11:0]};
  assign frame_end = info_end + POS_W'(CHK_DIGITS);
  assign sum_neg   = 16'd0 - running_sum;

  // Step the frame state for one byte
  always_comb begin
    pos_next           = pos;
    running_sum_next   = running_sum;
    hi_nibble_next     = hi_nibble;
    hdr_version_next   = hdr_version;
    hdr_address_next   = hdr_address;
    hdr_group_next     = hdr_group;
    hdr_return_next    = hdr_return;
    length_word_next   = length_word;
    rx_checksum_next   = rx_checksum;
    pend_err_next      = pend_err;
    verdict_given_next = verdict_given;
    verdict_hit        = 1'b0;
    info_hit           = 1'b0;
    clear_hit          = 1'b0;
    verdict_code       = ST_OK;

    if (verdict_given) begin
      // Drop bytes until the buffer ends
      clear_hit = last;
    end else if (last && pos < POS_W'(MIN_BUFFER_POS)) begin
      verdict_hit  = 1'b1;
      verdict_code = ST_SHORT_HEADER;
      clear_hit    = 1'b1;
    end else begin
      // Header bytes
      if (pos == '0) begin
        if (b != START_BYTE) begin
          pend_err_next = ST_BAD_START;
        end
      end else if (pos <= POS_W'(HEADER_LAST_POS) && pend_err == ST_OK) begin
        running_sum_next = running_sum + {8'h00, b};
        if (hex[4]) begin
          pend_err_next = ST_BAD_HEX;
        end else if (pos[0]) begin
          hi_nibble_next = hex[3:0];
        end else begin
          unique case (pos[3:1])
            3'd1: hdr_version_next = pair;
            3'd2: hdr_address_next = pair;
            3'd3: hdr_group_next   = pair;
            3'd4: begin
              hdr_return_next = pair;
              if (hdr_version != cfg.expected_version) begin
                pend_err_next = ST_BAD_VERSION;
              end else if (hdr_group != cfg.expected_group_code) begin
                pend_err_next = ST_BAD_GROUP;
              end
            end
            3'd5: length_word_next = {pair, 8'h00};
            3'd6: begin
              length_word_next = {length_word[15:8], pair};
              if (length_word[15:12] != nib_neg[3:0]) begin
                pend_err_next = ST_BAD_CHECKSUM;
              end
            end
            default: ;
          endcase
        end
      end

      // Advance, pass info, collect checksum or give the verdict
      if (pend_err_next != ST_OK && pend_err_next != ST_CHK_HEX_FAULT) begin
        if (pos >= POS_W'(MIN_BUFFER_POS)) begin
          verdict_hit  = 1'b1;
          verdict_code = pend_err_next;
          clear_hit    = last;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end else if (pos <= POS_W'(HEADER_LAST_POS)) begin
        pos_next = pos + POS_W'(1);
      end else if (last && pos < frame_end) begin
        verdict_hit  = 1'b1;
        verdict_code = ST_SHORT_PAYLOAD;
        clear_hit    = 1'b1;
      end else if (pos < info_end) begin
        running_sum_next = running_sum + {8'h00, b};
        pos_next         = pos + POS_W'(1);
        info_hit         = 1'b1;
      end else if (pos < frame_end) begin
        if (hex[4]) begin
          pend_err_next = ST_CHK_HEX_FAULT;
        end
        rx_checksum_next = {rx_checksum[11:0], hex[3:0]};
        pos_next         = pos + POS_W'(1);
      end else begin
        verdict_hit = 1'b1;
        clear_hit   = last;
        priority if (b != END_BYTE) begin
          verdict_code = ST_BAD_END;
        end else if (pend_err == ST_CHK_HEX_FAULT) begin
          verdict_code = ST_BAD_HEX;
        end else if (rx_checksum != sum_neg) begin
          verdict_code = ST_BAD_CHECKSUM;
        end else begin
          verdict_code = ST_OK;
        end
      end
    end

    if (verdict_hit) begin
      verdict_given_next = 1'b1;
    end

    // Clear the frame state at the end of a buffer
    if (clear_hit) begin
      pos_next           = '0;
      running_sum_next   = '0;
      hi_nibble_next     = '0;
      hdr_version_next   = '0;
      hdr_address_next   = '0;
      hdr_group_next     = '0;
      hdr_return_next    = '0;
      length_word_next   = '0;
      rx_checksum_next   = '0;
      pend_err_next      = ST_OK;
      verdict_given_next = 1'b0;
    end
  end

  // Build the result word
  always_comb begin
    res       = '0;
    res_valid = fire && (verdict_hit || info_hit);
    if (verdict_hit) begin
      res.is_status = 1'b1;
      res.status    = verdict_code;
      if (verdict_code == ST_OK) begin
        res.address     = hdr_address;
        res.return_code = hdr_return;
        res.info_length = length_word[11:0];
      end
    end else begin
      res.info_char = b;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      running_sum   <= '0;
      hi_nibble     <= '0;
      hdr_version   <= '0;
      hdr_address   <= '0;
      hdr_group     <= '0;
      hdr_return    <= '0;
      length_word   <= '0;
      rx_checksum   <= '0;
      pend_err      <= ST_OK;
      verdict_given <= 1'b0;
    end else if (fire) begin
      pos           <= pos_next;
      running_sum   <= running_sum_next;
      hi_nibble     <= hi_nibble_next;
      hdr_version   <= hdr_version_next;
      hdr_address   <= hdr_address_next;
      hdr_group     <= hdr_group_next;
      hdr_return    <= hdr_return_next;
      length_word   <= length_word_next;
      rx_checksum   <= rx_checksum_next;
      pend_err      <= pend_err_next;
      verdict_given <= verdict_given_next;
    end
  end

endmodule

### hw/rtl/ahfr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_out_stage
// Result register: holds a result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ahfr_out_stage
  import ahfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Room for a new word when empty or being drained
  assign free = !result_valid || !result_stall;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

### hw/rtl/ascii_hex_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_unit
// Receiver for ASCII-hex framed responses, one byte per word.
// ----------------------------------------------------------------------------
// Takes one byte of a received buffer per cycle, with last_byte on the final
// byte, and returns the info characters as they arrive followed by exactly one
// status word per buffer (address, return code and info length filled in only
// for a good frame). A byte is taken every cycle while the result side is not
// stalled. A byte with a result waits in the input register while the
// frame-state update computes that result, and the result register takes it
// once it has room. The update of the frame state (position, running sum,
// checks), made once for each byte, is what sets that rate.
// Configuration writes are always ready and take effect on the next byte.
module ascii_hex_frame_receiver_unit
  import ahfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  cfg_t    cfg;
  item_t   held;
  logic    held_valid;
  logic    out_free;
  logic    fire;
  logic    res_valid;
  result_t res;

  // Consume the held byte when the result register has room
  assign fire = held_valid && out_free;

  ahfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (fire),
    .held_valid (held_valid),
    .held       (held)
  );

  ahfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .held      (held),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ahfr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_valid),
    .res          (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### bench/ascii_hex_frame_receiver_unit_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_unit_chk
// Scoreboard for the ASCII-hex frame receiver.
// ----------------------------------------------------------------------------
// Watches the byte, result and register channels. Every accepted byte is run
// through a cycle-free model of the frame parser, which queues the info
// characters and the status word that the byte should produce. Every accepted
// result word is matched field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver_unit_chk
  import ahfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_stall,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     fail_count,
  output int                     words_due
);

  // Match values of the configuration registers
  logic [7:0] match_version;
  logic [7:0] match_group;

  // Frame parse state
  int unsigned frame_pos;
  logic [15:0] byte_sum;
  logic [3:0]  high_nib;
  logic [7:0]  hdr_bytes [4];
  logic [15:0] lenid_word;
  logic [15:0] chk_word;
  status_e     frame_fault;
  bit          verdict_sent;

  result_t expected_words [$];
  int      fails;

  // Decode one hex character of either case: {not_hex, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (folded >= "a" && folded <= "f") return {1'b0, 4'(folded - "a" + 10)};
    return 5'h10;
  endfunction

  // Drop everything learned about the current buffer, keep the registers
  function automatic void clear_frame();
    frame_pos = 0;
    byte_sum = '0;
    high_nib = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    lenid_word = '0;
    chk_word = '0;
    frame_fault = ST_OK;
    verdict_sent = 1'b0;
  endfunction

  // Keep only the first fault seen in frame order
  function automatic void flag_fault(input status_e code);
    if (frame_fault == ST_OK) frame_fault = code;
  endfunction

  // Queue the status word of the buffer
  function automatic void post_verdict(input status_e code, input bit wipe);
    result_t w;
    w = '0;
    w.is_status = 1'b1;
    w.status = code;
    if (code == ST_OK) begin
      w.address = hdr_bytes[1];
      w.return_code = hdr_bytes[3];
      w.info_length = lenid_word[11:0];
    end
    expected_words.push_back(w);
    verdict_sent = 1'b1;
    if (wipe) clear_frame();
  endfunction

  // Advance the frame parse by one byte and queue whatever it produces
  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    int unsigned pos;
    int unsigned info_len;
    logic [4:0]  dig;
    logic [7:0]  pair;
    logic [3:0]  nib_sum;
    result_t     w;
    pos = frame_pos;

    // Skip the rest of a buffer whose verdict is out
    if (verdict_sent) begin
      if (is_last) clear_frame();
      return;
    end
    if (is_last && pos < MIN_BUFFER_POS) begin
      post_verdict(ST_SHORT_HEADER, 1'b1);
      return;
    end

    // Start byte, then the header hex pairs
    if (pos == 0) begin
      if (b != START_BYTE) flag_fault(ST_BAD_START);
    end else if (pos <= HEADER_LAST_POS && frame_fault == ST_OK) begin
      byte_sum = byte_sum + b;
      dig = nibble_of(b);
      if (dig[4]) begin
        flag_fault(ST_BAD_HEX);
      end else if (pos % 2 == 1) begin
        high_nib = dig[3:0];
      end else begin
        pair = {high_nib, dig[3:0]};
        if (pos <= 8) hdr_bytes[pos / 2 - 1] = pair;
        if (pos == 8) begin
          if (hdr_bytes[0] != match_version) flag_fault(ST_BAD_VERSION);
          else if (hdr_bytes[2] != match_group) flag_fault(ST_BAD_GROUP);
        end else if (pos == 10) begin
          lenid_word = {pair, 8'h00};
        end else if (pos == 12) begin
          // All four LENID nibbles sum to zero modulo 16
          lenid_word[7:0] = pair;
          nib_sum = lenid_word[15:12] + lenid_word[11:8] + lenid_word[7:4]
                  + lenid_word[3:0];
          if (nib_sum != 4'd0) flag_fault(ST_BAD_CHECKSUM);
        end
      end
    end

    // Header faults wait for the 18th byte
    if (frame_fault != ST_OK && frame_fault != ST_CHK_HEX_FAULT) begin
      if (pos >= MIN_BUFFER_POS) post_verdict(frame_fault, is_last);
      else frame_pos = pos + 1;
      return;
    end
    if (pos <= HEADER_LAST_POS) begin
      frame_pos = pos + 1;
      return;
    end

    info_len = lenid_word[11:0];
    if (is_last && pos < MIN_BUFFER_POS + info_len) begin
      post_verdict(ST_SHORT_PAYLOAD, 1'b1);
      return;
    end

    // Pass info characters straight through
    if (pos < INFO_FIRST_POS + info_len) begin
      byte_sum = byte_sum + b;
      frame_pos = pos + 1;
      w = '0;
      w.info_char = b;
      expected_words.push_back(w);
      return;
    end

    // Collect the checksum digits
    if (pos < INFO_FIRST_POS + CHK_DIGITS + info_len) begin
      dig = nibble_of(b);
      if (dig[4]) flag_fault(ST_CHK_HEX_FAULT);
      chk_word = {chk_word[11:0], dig[3:0]};
      frame_pos = pos + 1;
      return;
    end

    // End byte: checksum plus running sum must wrap to zero
    if (b != END_BYTE) post_verdict(ST_BAD_END, is_last);
    else if (frame_fault == ST_CHK_HEX_FAULT) post_verdict(ST_BAD_HEX, is_last);
    else if (chk_word + byte_sum != 16'h0000) post_verdict(ST_BAD_CHECKSUM, is_last);
    else post_verdict(ST_OK, is_last);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endfunction

  // Match one result word against the oldest prediction
  function automatic void check_word(input result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      $error("result word with nothing predicted: %h", got);
      fails++;
      return;
    end
    want = expected_words.pop_front();
    compare_field("is_status", want.is_status, got.is_status);
    compare_field("info_char", want.info_char, got.info_char);
    compare_field("status", want.status, got.status);
    compare_field("address", want.address, got.address);
    compare_field("return_code", want.return_code, got.return_code);
    compare_field("info_length", want.info_length, got.info_length);
  endfunction

  // Track register writes, bytes in and words out on every edge
  always @(posedge clk) begin
    if (rst) begin
      match_version = VERSION_RESET;
      match_group = GROUP_RESET;
      clear_frame();
      expected_words.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPECTED_VERSION: match_version = cfg_data;
          REG_EXPECTED_GROUP:   match_group = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) parse_byte(item.rx_byte, item.last_byte);
      if (result_valid && !result_stall) check_word(result);
    end
    fail_count <= fails;
    words_due <= expected_words.size();
  end

endmodule

### bench/ascii_hex_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_unit_tb
// Top-level bench for the ASCII-hex frame receiver.
// ----------------------------------------------------------------------------
// Builds byte buffers holding framed responses: first a handful of hand-made
// frames hitting every status code, then phases of random frames, mostly
// well formed, some with one fault injected, some plain noise. The match
// registers change between phases. The byte side sends in bursts with gaps,
// the result side stalls on its own pattern and once holds off for a long
// stretch. The scoreboard beside the block predicts and checks every word.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver_unit_tb;
  import ahfr_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  item_t                  item;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;
  int                     fail_count;
  int                     words_due;

  item_t      tx_words [$];
  logic [7:0] frame_bytes [$];
  logic [7:0] cur_version;
  logic [7:0] cur_group;
  bit         hold_off_req;

  ascii_hex_frame_receiver_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ascii_hex_frame_receiver_unit_chk u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_due    (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: stall on a changing pattern, hold off long when asked
  initial begin : result_side
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 100);
      while (span > 0 && !hold_off_req) begin
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 99) < 30);
          2:       result_stall <= (tick % 5 >= 3);
          default: result_stall <= ($urandom_range(0, 99) < 60);
        endcase
        tick++;
        span--;
        @(posedge clk);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x);
    return c;
  endfunction

  // Hex digit in a random case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
  endfunction

  function automatic void put_hex(input logic [15:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) frame_bytes.push_back(hex_char(value[4*i +: 4]));
  endfunction

  // Build a complete frame; nonzero error masks spoil the LENID or checksum
  function automatic void make_frame(input logic [7:0] ver, input logic [7:0] addr,
                                     input logic [7:0] grp, input logic [7:0] rc,
                                     input logic [11:0] len, input logic [3:0] lenid_err,
                                     input logic [15:0] chk_err);
    logic [3:0]  lenid_top;
    logic [15:0] sum;
    frame_bytes.delete();
    frame_bytes.push_back(START_BYTE);
    put_hex(ver, 2);
    put_hex(addr, 2);
    put_hex(grp, 2);
    put_hex(rc, 2);
    lenid_top = 4'd0 - (len[11:8] + len[7:4] + len[3:0]);
    put_hex({lenid_top ^ lenid_err, len}, 4);
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    for (int i = 1; i < frame_bytes.size(); i++) sum = sum + frame_bytes[i];
    sum = 16'h0000 - sum;
    put_hex(sum ^ chk_err, 4);
    frame_bytes.push_back(END_BYTE);
  endfunction

  function automatic void trim(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  // Move the built buffer to the send queue, flag its final byte
  function automatic void queue_buffer();
    item_t w;
    foreach (frame_bytes[i]) begin
      w.rx_byte = frame_bytes[i];
      w.last_byte = (i == frame_bytes.size() - 1);
      tx_words.push_back(w);
    end
  endfunction

  // One random buffer: mostly clean frames, some with one fault, some noise
  function automatic void random_buffer(input int info_max);
    int          kind;
    int          fault;
    int          n;
    logic [11:0] len;
    logic [7:0]  ver;
    logic [7:0]  grp;
    logic [3:0]  lenid_err;
    logic [15:0] chk_err;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      frame_bytes.delete();
      n = $urandom_range(1, 30);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) frame_bytes[0] = START_BYTE;
      queue_buffer();
      return;
    end
    len = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, info_max))
                                      : 12'($urandom_range(0, 6));
    ver = cur_version;
    grp = cur_group;
    lenid_err = '0;
    chk_err = '0;
    fault = (kind < 62) ? -1 : $urandom_range(0, 10);

    // Faults that shape the frame contents
    case (fault)
      2:  ver = ver ^ 8'($urandom_range(1, 255));
      3:  grp = grp ^ 8'($urandom_range(1, 255));
      4:  lenid_err = 4'($urandom_range(1, 15));
      8:  chk_err = 16'($urandom_range(1, 65535));
      10: len = 12'($urandom_range(100, 4095));
      default: ;
    endcase
    make_frame(ver, 8'($urandom), grp, 8'($urandom), len, lenid_err, chk_err);

    // Faults that damage the built bytes
    case (fault)
      0: frame_bytes[0] = other_than(START_BYTE);
      1: frame_bytes[$urandom_range(1, 12)] = non_hex_byte();
      5: trim($urandom_range(1, frame_bytes.size() - 1));
      6: frame_bytes[frame_bytes.size() - 1] = other_than(END_BYTE);
      7: begin
        frame_bytes[frame_bytes.size() - 2 - $urandom_range(0, 3)] = non_hex_byte();
        if ($urandom_range(0, 1)) frame_bytes[frame_bytes.size() - 1] = other_than(END_BYTE);
      end
      9: repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      10: trim($urandom_range(14, 60));
      default: ;
    endcase
    queue_buffer();
  endfunction

  // Send the queued bytes in bursts with random gaps
  task automatic drive_bytes();
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 60);
    while (tx_words.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end
      item_valid <= 1'b1;
      item <= tx_words[0];
      @(posedge clk);
      if (!item_stall) begin
        void'(tx_words.pop_front());
        burst_left--;
      end
    end
    item_valid <= 1'b0;
  endtask

  // Wait for every predicted word, then let the pipeline run dry
  task automatic drain();
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write both match registers back to back
  task automatic program_match(input logic [7:0] ver, input logic [7:0] grp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EXPECTED_VERSION;
    cfg_data <= ver;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_EXPECTED_GROUP;
    cfg_data <= grp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_version = ver;
    cur_group = grp;
  endtask

  task automatic run_phase(input logic [7:0] ver, input logic [7:0] grp,
                           input int info_max, input bit hold);
    program_match(ver, grp);
    while (tx_words.size() < 80) random_buffer(info_max);
    if (hold) hold_off_req = 1'b1;
    drive_bytes();
    drain();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur_version = VERSION_RESET;
    cur_group = GROUP_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Clean frames: empty info field and a short one, field extremes
    make_frame(cur_version, 8'h00, cur_group, 8'hFF, 12'd0, 4'h0, 16'h0);
    queue_buffer();
    make_frame(cur_version, 8'hFF, cur_group, 8'h00, 12'd3, 4'h0, 16'h0);
    queue_buffer();
    // Short header: a lone byte, and one byte short of the minimum
    frame_bytes.delete();
    frame_bytes.push_back(START_BYTE);
    queue_buffer();
    make_frame(cur_version, 8'h12, cur_group, 8'h34, 12'd0, 4'h0, 16'h0);
    trim(17);
    queue_buffer();
    // Bad start byte
    make_frame(cur_version, 8'h55, cur_group, 8'hAA, 12'd1, 4'h0, 16'h0);
    frame_bytes[0] = 8'h00;
    queue_buffer();
    // Non-hex header digit
    make_frame(cur_version, 8'h55, cur_group, 8'hAA, 12'd1, 4'h0, 16'h0);
    frame_bytes[1] = "G";
    queue_buffer();
    // Wrong version, wrong group, LENID check failure
    make_frame(cur_version ^ 8'h01, 8'h01, cur_group, 8'h02, 12'd0, 4'h0, 16'h0);
    queue_buffer();
    make_frame(cur_version, 8'h01, cur_group ^ 8'h80, 8'h02, 12'd0, 4'h0, 16'h0);
    queue_buffer();
    make_frame(cur_version, 8'h01, cur_group, 8'h02, 12'd5, 4'h1, 16'h0);
    queue_buffer();
    // Longest LENID with the buffer ending among the info characters
    make_frame(cur_version, 8'h01, cur_group, 8'h02, 12'hFFF, 4'h0, 16'h0);
    trim(20);
    queue_buffer();
    // Buffer ending inside the checksum digits
    make_frame(cur_version, 8'h01, cur_group, 8'h02, 12'd2, 4'h0, 16'h0);
    trim(18);
    queue_buffer();
    // Bad end byte
    make_frame(cur_version, 8'h03, cur_group, 8'h04, 12'd1, 4'h0, 16'h0);
    frame_bytes[frame_bytes.size() - 1] = 8'h0A;
    queue_buffer();
    // Non-hex checksum digit, alone and with a bad end byte
    make_frame(cur_version, 8'h03, cur_group, 8'h04, 12'd1, 4'h0, 16'h0);
    frame_bytes[frame_bytes.size() - 3] = "z";
    queue_buffer();
    make_frame(cur_version, 8'h03, cur_group, 8'h04, 12'd1, 4'h0, 16'h0);
    frame_bytes[frame_bytes.size() - 3] = "z";
    frame_bytes[frame_bytes.size() - 1] = 8'h7E;
    queue_buffer();
    // Wrong checksum value
    make_frame(cur_version, 8'h03, cur_group, 8'h04, 12'd2, 4'h0, 16'h8001);
    queue_buffer();
    // Bytes after the verdict: after a good frame and after a header fault
    make_frame(cur_version, 8'hC3, cur_group, 8'h3C, 12'd2, 4'h0, 16'h0);
    repeat (3) frame_bytes.push_back(8'($urandom));
    queue_buffer();
    make_frame(cur_version ^ 8'h40, 8'hC3, cur_group, 8'h3C, 12'd2, 4'h0, 16'h0);
    repeat (3) frame_bytes.push_back(8'($urandom));
    queue_buffer();
    drive_bytes();
    drain();

    // Random phases across register settings; one holds off the result side
    run_phase(8'h00, 8'h00, 12, 1'b0);
    run_phase(8'hFF, 8'hFF, 12, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 60, 1'b1);
    run_phase(VERSION_RESET, GROUP_RESET, 200, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 12, 1'b0);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ahfr_pkg.sv
hw/rtl/ahfr_cfg_regs.sv
hw/rtl/ahfr_in_stage.sv
hw/rtl/ahfr_parser.sv
hw/rtl/ahfr_out_stage.sv
hw/rtl/ascii_hex_frame_receiver_unit.sv
bench/ascii_hex_frame_receiver_unit_chk.sv
bench/ascii_hex_frame_receiver_unit_tb.sv
